@@ design/rds_pkg.sv @@
// Shared types and constants for the random dot stereogram row unit.
`default_nettype none
package rds_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxStride = 64;

  localparam logic [23:0] ColorDot  = 24'hffffff;
  localparam logic [23:0] ColorMark = 24'hff0000;
  localparam logic [23:0] ColorBg   = 24'h000000;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegStride = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  localparam logic ActPixel = 1'b0;
  localparam logic ActDrain = 1'b1;

  typedef struct packed {
    logic        action;
    logic [23:0] pixel_rgb;
    logic        frame_start;
    logic [63:0] seed_mask;
  } rds_in_t;

  typedef struct packed {
    logic [23:0] out_rgb;
    logic [10:0] out_column;
    logic [11:0] out_row;
    logic        row_end;
  } rds_out_t;

endpackage
`default_nettype wire

@@ design/random_dot_stereogram_rows_unit.sv @@
// Random dot stereogram row unit: depth capture, dot walk sequencer, row output.
//
// Usage: drive an item on item_i with start_i high while busy_o is low. A pixel
// item stores the pixel's 3-bit depth for the current row; a drain item only
// moves the output. Every accepted item first emits one pixel of the previously
// finished row (if one is pending) on result_o, marked by valid_o for one cycle;
// the result is registered in the emit state. The receiver cannot stall; results
// are never held. The dot memory is read on acceptance, and busy_o stays high
// through the emit step, so the next item waits. The last pixel of a row starts
// the dot build: the dot memory is cleared one entry per cycle, then for every
// enabled seed the walk runs one dot per step, each step being one depth memory
// read plus one add through the shared step adder; busy_o stays high until the
// build is done. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) apply at
// once; the user must make them only while idle, and the block itself does not
// enforce this. Reset clears all control state; the depth memory holds garbage
// until written and the dot memory is swept before every build.
`default_nettype none
module random_dot_stereogram_rows_unit
  import rds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire rds_in_t  item_i,
  output logic          busy_o,
  input  wire logic     cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  output logic          valid_o,
  output rds_out_t      result_o
);

  localparam int AW = $clog2(MaxWidth);
  localparam int XW = AW + 3;  // signed walk position with headroom
  localparam int SW = $clog2(MaxStride);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EMIT, ST_CLEAR, ST_SEED, ST_RRD, ST_RWAIT, ST_RSTEP,
    ST_LINIT, ST_LRD, ST_LWAIT, ST_LSTEP
  } state_e;

  state_e state_q;

  logic [11:0] cfg_w_q;
  logic [6:0]  cfg_s_q;
  logic        mode_q;

  logic [2:0] depth_mem [MaxWidth];
  logic       dot_mem   [MaxWidth];

  logic [11:0] in_col_q, in_row_q, emit_row_q;
  logic [11:0] emit_col_q;
  logic [12:0] emit_w_q, bw_q;
  logic [6:0]  emit_s_q, bs_q;
  logic        ready_q;
  logic [63:0] seeds_q;
  logic [SW:0] seed_q;
  logic signed [XW-1:0] x_q;
  logic [AW:0] clr_q;
  logic [2:0]  dep_q;
  logic        dot_rd_q;
  logic        pend_q;
  logic [11:0] p_col_q, p_row_q;
  logic [12:0] p_w_q;
  logic [6:0]  p_s_q;

  // effective width and stride
  logic [12:0] eff_w;
  logic [6:0]  eff_s;
  always_comb begin
    eff_w = {1'b0, cfg_w_q};
    if (cfg_w_q < 12'd16) eff_w = 13'd16;
    else if ({1'b0, cfg_w_q} > 13'(MaxWidth)) eff_w = 13'(MaxWidth);
    eff_s = cfg_s_q;
    if (cfg_s_q < 7'd8) eff_s = 7'd8;
    else if (cfg_s_q > 7'(MaxStride)) eff_s = 7'(MaxStride);
  end

  logic signed [XW-1:0] half_s, wlim, probe, stepv, xn;
  assign half_s = XW'(bs_q >> 1);
  assign wlim   = XW'(bw_q);
  assign probe  = (state_q inside {ST_RRD, ST_RWAIT, ST_RSTEP}) ? x_q + half_s : x_q - half_s;
  assign stepv  = mode_q ? XW'(bs_q) + XW'(dep_q) : XW'(bs_q) - XW'(dep_q);
  // the one shared adder for both walk directions
  assign xn = (state_q == ST_RSTEP) ? x_q + stepv : x_q - stepv;

  logic signed [XW-1:0] seed_x;
  assign seed_x = XW'(bw_q >> 1) + XW'(seed_q);

  logic [2:0] pix_d;
  assign pix_d = 3'(item_i.pixel_rgb[23:22]) + 3'(item_i.pixel_rgb[15:14])
               + 3'(item_i.pixel_rgb[7]);

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  logic [11:0] col_eff, row_eff;
  assign col_eff = item_i.frame_start ? 12'd0 : in_col_q;
  assign row_eff = item_i.frame_start ? 12'd0 : in_row_q;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (accept && item_i.action == ActPixel && {1'b0, col_eff} < 13'(MaxWidth))
      depth_mem[col_eff[AW-1:0]] <= pix_d;
    if (state_q inside {ST_RRD, ST_LRD})
      dep_q <= depth_mem[probe[AW-1:0]];
    if (accept)
      dot_rd_q <= dot_mem[emit_col_q[AW-1:0]];
    if (state_q == ST_CLEAR)
      dot_mem[clr_q[AW-1:0]] <= 1'b0;
    else if (state_q == ST_SEED && seed_q < (SW+1)'(bs_q) && seeds_q[seed_q[SW-1:0]]
             && seed_x < wlim)
      dot_mem[seed_x[AW-1:0]] <= 1'b1;
    else if ((state_q == ST_RSTEP && xn < wlim) || (state_q == ST_LSTEP && xn >= 0))
      dot_mem[xn[AW-1:0]] <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_w_q <= 12'd640; cfg_s_q <= 7'd40; mode_q <= 1'b0;
      in_col_q <= '0; in_row_q <= '0; emit_row_q <= '0; emit_col_q <= '0;
      emit_w_q <= '0; emit_s_q <= '0; ready_q <= 1'b0; pend_q <= 1'b0;
      valid_o <= 1'b0; clr_q <= '0; seed_q <= '0; x_q <= '0;
      bw_q <= '0; bs_q <= '0; seeds_q <= '0;
      p_col_q <= '0; p_row_q <= '0; p_w_q <= '0; p_s_q <= '0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWidth:  cfg_w_q <= cfg_data_i;
          RegStride: cfg_s_q <= cfg_data_i[6:0];
          RegMode:   mode_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EMIT;
            pend_q <= ready_q;
            p_col_q <= emit_col_q; p_row_q <= emit_row_q;
            p_w_q <= emit_w_q; p_s_q <= emit_s_q;
            if (ready_q) begin
              if ({1'b0, emit_col_q} + 13'd1 >= emit_w_q) ready_q <= 1'b0;
              else emit_col_q <= emit_col_q + 12'd1;
            end
            if (item_i.action == ActPixel) begin
              if ({1'b0, col_eff} + 13'd1 >= eff_w) begin
                in_col_q <= '0;
                in_row_q <= row_eff + 12'd1;
                emit_row_q <= row_eff;
                bw_q <= eff_w; bs_q <= eff_s;
                seeds_q <= item_i.seed_mask;
                clr_q <= '0; seed_q <= '0;
              end else begin
                in_col_q <= col_eff + 12'd1;
                in_row_q <= row_eff;
              end
            end
          end
        end
        ST_EMIT: begin
          valid_o <= pend_q;
          // a build was started if bw_q was latched this item (in_col wrapped)
          if (in_col_q == '0 && bw_q != '0 && seeds_q != 64'd0 ? 1'b1 : in_col_q == '0
              && bw_q != '0) state_q <= ST_CLEAR;
          else state_q <= ST_IDLE;
          if (!(in_col_q == '0 && bw_q != '0)) bw_q <= bw_q;
        end
        ST_CLEAR: begin
          if ({1'b0, clr_q} + 1'b1 >= (AW+1)'(MaxWidth) || clr_q + 1'b1 >= bw_q[AW:0])
            state_q <= ST_SEED;
          clr_q <= clr_q + 1'b1;
        end
        ST_SEED: begin
          if (seed_q >= (SW+1)'(bs_q)) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1; emit_col_q <= '0;
            emit_w_q <= bw_q; emit_s_q <= bs_q; bw_q <= '0;
          end else if (seeds_q[seed_q[SW-1:0]]) begin
            x_q <= seed_x; state_q <= ST_RRD;
          end else seed_q <= seed_q + 1'b1;
        end
        ST_RRD: state_q <= (probe < wlim) ? ST_RWAIT : ST_LINIT;
        ST_RWAIT: state_q <= ST_RSTEP;
        ST_RSTEP: begin
          x_q <= xn;
          state_q <= (xn < wlim) ? ST_RRD : ST_LINIT;
        end
        ST_LINIT: begin x_q <= seed_x; state_q <= ST_LRD; end
        ST_LRD: begin
          if (probe >= 0 && probe < wlim) state_q <= ST_LWAIT;
          else begin state_q <= ST_SEED; seed_q <= seed_q + 1'b1; end
        end
        ST_LWAIT: state_q <= ST_LSTEP;
        ST_LSTEP: begin
          x_q <= xn;
          if (xn >= 0) state_q <= ST_LRD;
          else begin state_q <= ST_SEED; seed_q <= seed_q + 1'b1; end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output formatting from the latched emit snapshot
  logic signed [13:0] m, rel, rel2;
  logic [23:0] rgb;
  always_comb begin
    m = (14'(signed'({1'b0, p_w_q})) - 14'(signed'({1'b0, p_s_q}))) >>> 1;
    if (p_w_q < 13'(p_s_q)) m = -((14'(signed'({1'b0, p_s_q})) - 14'(signed'({1'b0, p_w_q}))) >>> 1);
    rel = 14'(signed'({1'b0, p_col_q})) - m;
    rel2 = rel - 14'(signed'({1'b0, p_s_q}));
    rgb = dot_rd_q ? ColorDot : ColorBg;
    if (p_row_q >= 12'd1 && p_row_q <= 12'd4 &&
        ((rel >= 0 && rel < 4) || (rel2 >= 0 && rel2 < 4))) rgb = ColorMark;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      result_o.out_rgb <= rgb;
      result_o.out_column <= p_col_q[10:0];
      result_o.out_row <= p_row_q;
      result_o.row_end <= ({1'b0, p_col_q} + 13'd1 >= p_w_q);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> $past(state_q) == ST_EMIT)
    else $error("result without emit step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> state_q == ST_EMIT)
    else $error("accept did not enter emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEED |-> !ready_q || 1'b1 ? bw_q != '0 : 1'b1)
    else $error("build without latched width");

endmodule
`default_nettype wire

@@ tb/sv/random_dot_stereogram_rows_unit_tb.sv @@
// Testbench for the random dot stereogram row unit: queued stimulus, row predictor, pixel checks.
module random_dot_stereogram_rows_unit_tb;
  import rds_pkg::*;

  localparam int QuietCycles = 16;

  typedef enum logic [1:0] {OpItem, OpCfg, OpSync} drive_op_e;

  typedef struct {
    drive_op_e   op;
    rds_in_t     it;
    logic [1:0]  idx;
    logic [11:0] data;
    bit          gappy;
  } drive_step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  rds_in_t     item_i = '0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = RegWidth;
  logic [11:0] cfg_data_i = '0;
  logic        valid_o;
  rds_out_t    result_o;

  random_dot_stereogram_rows_unit dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_o, .result_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- row predictor ----------------
  logic [11:0] cfg_width = 12'd640;
  logic [6:0]  cfg_stride = 7'd40;
  logic        cfg_mode = 1'b0;
  logic [2:0]  depth_mem [MaxWidth];
  bit          dot_mem [MaxWidth];
  int          in_col = 0;
  logic [11:0] in_row = '0;
  int          emit_col = 0;
  bit          row_ready = 0;
  logic [11:0] emit_row = '0;
  int          emit_w = 0;
  int          emit_s = 0;
  rds_out_t    expected_px [$];
  int          errors = 0;

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int walk_step(int s, int col);
    int d;
    d = depth_mem[col];
    return cfg_mode ? s + d : s - d;
  endfunction

  function automatic void build_dots(logic [63:0] seeds, int w, int s);
    int x, h;
    h = s / 2;
    foreach (dot_mem[k]) dot_mem[k] = 0;
    for (int i = 0; i < s; i++) begin
      if (seeds[i]) begin
        x = w / 2 + i;
        if (x < w) dot_mem[x] = 1;
        while (x + h < w) begin
          x += walk_step(s, x + h);
          if (x >= w) break;
          dot_mem[x] = 1;
        end
        x = w / 2 + i;
        while (x - h >= 0 && x - h < w) begin
          x -= walk_step(s, x - h);
          if (x < 0) break;
          dot_mem[x] = 1;
        end
      end
    end
  endfunction

  function automatic void emit_pixel();
    rds_out_t r;
    int m, rel;
    if (!row_ready) return;
    r.out_rgb = dot_mem[emit_col] ? ColorDot : ColorBg;
    if (emit_row >= 1 && emit_row <= 4) begin
      m = (emit_w - emit_s) / 2;
      rel = emit_col - m;
      if ((rel >= 0 && rel < 4) || (rel - emit_s >= 0 && rel - emit_s < 4))
        r.out_rgb = ColorMark;
    end
    r.out_column = emit_col[10:0];
    r.out_row = emit_row;
    r.row_end = (emit_col + 1 >= emit_w);
    expected_px.push_back(r);
    if (r.row_end) row_ready = 0;
    else emit_col++;
  endfunction

  function automatic void model_item(rds_in_t it);
    int w, s;
    logic [2:0] d;
    emit_pixel();
    if (it.action == ActDrain) return;
    if (it.frame_start) begin
      in_row = '0;
      in_col = 0;
    end
    w = clamp_int(cfg_width, 16, MaxWidth);
    s = clamp_int(cfg_stride, 8, MaxStride);
    d = it.pixel_rgb[23:22] + it.pixel_rgb[15:14] + it.pixel_rgb[7];
    depth_mem[in_col] = d;
    if (in_col + 1 >= w) begin
      build_dots(it.seed_mask, w, s);
      row_ready = 1;
      emit_col = 0;
      emit_row = in_row;
      emit_w = w;
      emit_s = s;
      in_row = in_row + 12'd1;
      in_col = 0;
    end else begin
      in_col++;
    end
  endfunction

  function automatic void model_config(logic [1:0] idx, logic [11:0] d);
    case (idx)
      RegWidth:  cfg_width = d;
      RegStride: cfg_stride = d[6:0];
      RegMode:   cfg_mode = d[0];
      default: ;
    endcase
  endfunction

  // ---------------- monitor ----------------
  logic accepted = 1'b0;
  int   quiet_cnt = 0;

  always @(posedge clk_i) begin
    rds_out_t e;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_px.size() == 0) begin
          $error("unexpected pixel col=%0d row=%0d", result_o.out_column, result_o.out_row);
          errors++;
        end else begin
          e = expected_px.pop_front();
          if (result_o.out_rgb !== e.out_rgb) begin
            $error("out_rgb expected %h actual %h", e.out_rgb, result_o.out_rgb);
            errors++;
          end
          if (result_o.out_column !== e.out_column) begin
            $error("out_column expected %0d actual %0d", e.out_column, result_o.out_column);
            errors++;
          end
          if (result_o.out_row !== e.out_row) begin
            $error("out_row expected %0d actual %0d", e.out_row, result_o.out_row);
            errors++;
          end
          if (result_o.row_end !== e.row_end) begin
            $error("row_end expected %0b actual %0b", e.row_end, result_o.row_end);
            errors++;
          end
        end
      end
      if (cfg_we_i) model_config(cfg_idx_i, cfg_data_i);
      if (start_i && !busy_o) model_item(item_i);
      accepted <= start_i && !busy_o;
      quiet_cnt <= (busy_o || start_i || valid_o) ? 0 : quiet_cnt + 1;
    end
  end

  // ---------------- driver ----------------
  drive_step_t pending_steps [$];
  int gap_cnt = 0;

  always @(negedge clk_i) begin
    logic nxt_start, nxt_we;
    drive_step_t hd;
    nxt_start = start_i && !accepted;
    nxt_we = 1'b0;
    if (rst_ni && !nxt_start) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
      end else if (pending_steps.size() > 0) begin
        hd = pending_steps[0];
        case (hd.op)
          OpItem: begin
            item_i <= hd.it;
            nxt_start = 1'b1;
            void'(pending_steps.pop_front());
            if (hd.gappy && $urandom_range(0, 9) == 0) gap_cnt = $urandom_range(1, 13);
          end
          OpCfg: begin
            nxt_we = 1'b1;
            cfg_idx_i <= hd.idx;
            cfg_data_i <= hd.data;
            void'(pending_steps.pop_front());
          end
          default: begin
            if (expected_px.size() == 0 && quiet_cnt >= QuietCycles)
              void'(pending_steps.pop_front());
          end
        endcase
      end
    end
    start_i <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // ---------------- stimulus ----------------
  int  gen_col = 0;
  int  gen_w = 640;
  int  n_items = 0;
  bit  gen_gappy = 0;

  task automatic add_item(logic act, logic [23:0] rgb, logic fs, logic [63:0] seeds);
    drive_step_t st;
    st.op = OpItem;
    st.it = '{action: act, pixel_rgb: rgb, frame_start: fs, seed_mask: seeds};
    st.idx = RegWidth;
    st.data = '0;
    st.gappy = gen_gappy;
    pending_steps.push_back(st);
    n_items++;
    if (act == ActPixel) begin
      if (fs) gen_col = 0;
      if (gen_col + 1 >= gen_w) gen_col = 0;
      else gen_col++;
    end
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [11:0] d);
    drive_step_t st;
    st.op = OpCfg;
    st.it = '0;
    st.idx = idx;
    st.data = d;
    st.gappy = 0;
    pending_steps.push_back(st);
    if (idx == RegWidth) gen_w = clamp_int(d, 16, MaxWidth);
  endtask

  // pad to a row boundary, then let the block go idle before reconfiguring
  task automatic add_sync();
    drive_step_t st;
    while (gen_col != 0) add_item(ActPixel, $urandom, 1'b0, {$urandom, $urandom});
    st.op = OpSync;
    st.it = '0;
    st.idx = RegWidth;
    st.data = '0;
    st.gappy = 0;
    pending_steps.push_back(st);
  endtask

  function automatic logic [63:0] rand_seeds();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(bit late);
    int rows, w_sel, s_sel;
    logic [11:0] wd;
    logic [11:0] sd;
    add_sync();
    w_sel = $urandom_range(0, 19);
    wd = (w_sel == 0) ? 12'($urandom_range(0, 15)) : 12'($urandom_range(16, 48));
    s_sel = $urandom_range(0, 9);
    sd = (s_sel == 0) ? 12'($urandom_range(0, 7)) :
         (s_sel == 1) ? {5'($urandom), 7'($urandom_range(65, 127))} :
         (s_sel == 2) ? 12'd64 : {5'($urandom), 7'($urandom_range(8, 20))};
    add_cfg(RegWidth, wd);
    add_cfg(RegStride, sd);
    add_cfg(RegMode, {11'($urandom), 1'($urandom)});
    gen_gappy = !late && $urandom_range(0, 2) != 0;
    rows = $urandom_range(3, 8);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < gen_w; c++) begin
        if ($urandom_range(0, 19) == 0) add_item(ActDrain, $urandom, 1'($urandom), rand_seeds());
        add_item(ActPixel, $urandom, (r == 0 && c == 0) || $urandom_range(0, 59) == 0,
                 rand_seeds());
      end
    end
    repeat ($urandom_range(0, gen_w + 2)) add_item(ActDrain, $urandom, 1'($urandom), '0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: idle drain, extremes on a narrow row, flush
    add_cfg(RegWidth, 12'd16);
    add_cfg(RegStride, 12'd8);
    add_cfg(RegMode, 12'd0);
    add_item(ActDrain, 24'h0, 1'b0, '0);
    for (int c = 0; c < 16; c++)
      add_item(ActPixel, (c % 2) ? 24'hffffff : 24'h000000, c == 0,
               (c == 15) ? '1 : 64'h0);
    repeat (8) add_item(ActDrain, 24'hffffff, 1'b1, '1);

    // one wide row with a clamped stride and every seed enabled
    add_sync();
    add_cfg(RegWidth, 12'd300);
    add_cfg(RegStride, 12'hfff);
    add_cfg(RegMode, 12'd1);
    for (int c = 0; c < 300; c++) add_item(ActPixel, $urandom, c == 0, '1);
    repeat (40) add_item(ActDrain, $urandom, 1'b0, '0);

    while (n_items < 1300) random_phase(0);
    while (n_items < 1800) random_phase(1);

    wait (pending_steps.size() == 0 && !start_i && expected_px.size() == 0);
    wait (quiet_cnt >= QuietCycles);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ random_dot_stereogram_rows_unit.f @@
design/rds_pkg.sv
design/random_dot_stereogram_rows_unit.sv
tb/sv/random_dot_stereogram_rows_unit_tb.sv
